// ===== design/kway_merge_newest_wins_assert.svh =====
// ----------------------------------------------------------------------------
// K-way merge assertion macros
// Shared concurrent assertion helpers for the merge block.
// ----------------------------------------------------------------------------
`ifndef KWAY_MERGE_NEWEST_WINS_ASSERT_SVH
`define KWAY_MERGE_NEWEST_WINS_ASSERT_SVH

// Clocked check, disabled while reset is high.
`define KWM_ASSERT(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("kwm assertion failed");

// Same, with a caller supplied message.
`define KWM_ASSERT_MSG(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error(msg);

`endif

// ===== design/kwm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// K-way merge package
// Field widths, register indexes and transaction payload types.
// ----------------------------------------------------------------------------
package kwm_pkg;

   localparam int RUN_INDEX_BITS = 3;
   localparam int KEY_FIELD_BITS = 64;
   localparam int VALUE_BITS     = 64;
   localparam int REFILL_BITS    = 8;
   localparam int ACTIVE_BITS    = 4;
   localparam int CSR_ADDR_BITS  = 1;
   localparam int CSR_DATA_BITS  = 4;

   localparam int NUM_RUNS_DEFAULT = 8;
   localparam int KEY_BITS_DEFAULT = 64;

   localparam logic [ACTIVE_BITS-1:0] ACTIVE_RESET = 4'd8;

   typedef enum logic [CSR_ADDR_BITS-1:0] {
      REG_DROP_TOMBSTONES = 1'b0,
      REG_ACTIVE_RUNS     = 1'b1
   } csr_reg_type;

   typedef struct packed {
      logic [RUN_INDEX_BITS-1:0] run_index;
      logic                      run_end;
      logic [KEY_FIELD_BITS-1:0] entry_key;
      logic [VALUE_BITS-1:0]     entry_value;
      logic                      entry_tombstone;
   } req_payload_type;

   typedef struct packed {
      logic                      out_valid;
      logic [KEY_FIELD_BITS-1:0] out_key;
      logic [VALUE_BITS-1:0]     out_value;
      logic                      out_tombstone;
      logic [REFILL_BITS-1:0]    refill_mask;
      logic                      merge_done;
   } rsp_payload_type;

endpackage

// ===== design/kwm_stream_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// K-way merge stream interface
// Valid/ready channel carrying one payload per transaction.
// ----------------------------------------------------------------------------
interface kwm_stream_if #(
   parameter type payload_type = logic
) ();
   logic        valid;
   logic        ready;
   payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// ===== design/kwm_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// K-way merge RAM
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module kwm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/kway_merge_newest_wins.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// K-way merge, newest wins
// Merges key-sorted runs into one sorted stream; on equal keys the
// highest-numbered run wins and older copies are consumed without output.
// ----------------------------------------------------------------------------
//  channel   dir   handshake        carries
//  req_if    in    valid/ready      run entry or end mark for one run
//  rsp_if    out   valid/ready      merged entry, refill mask, done flag
//  csr_*     in    csr_we only      drop_tombstones, active_runs
//
//  One transaction in, one transaction out. When a selection runs, the head
//  RAM has one read port, so the minimum search reads one head per cycle.
//  Reset is synchronous; head RAM contents are not cleared (present bits gate
//  every read). req_if.ready is high only between items; a stalled rsp_if
//  holds the finished result in the output register and the next item is
//  still taken, parking only when its own result is due.
`include "kway_merge_newest_wins_assert.svh"

module kway_merge_newest_wins #(
   parameter int NUM_RUNS = kwm_pkg::NUM_RUNS_DEFAULT,
   parameter int KEY_BITS = kwm_pkg::KEY_BITS_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_we,
   input  logic [kwm_pkg::CSR_ADDR_BITS-1:0] csr_addr,
   input  logic [kwm_pkg::CSR_DATA_BITS-1:0] csr_wdata,
   kwm_stream_if.sink                       req_if,
   kwm_stream_if.source                     rsp_if
);

   localparam int RUN_IDX_BITS = $clog2(NUM_RUNS);
   localparam int CNT_BITS     = $clog2(NUM_RUNS + 1);
   localparam int CMP_BITS     = (CNT_BITS > kwm_pkg::ACTIVE_BITS) ?
                                 CNT_BITS : kwm_pkg::ACTIVE_BITS;
   localparam int HEAD_BITS    = KEY_BITS + kwm_pkg::VALUE_BITS + 1;

   typedef enum logic [1:0] {S_IDLE, S_CHECK, S_SCAN, S_DONE} state_type;

   state_type                       state_ff, state_in;
   logic                            drop_ff;
   logic [kwm_pkg::ACTIVE_BITS-1:0] active_ff;
   logic [NUM_RUNS-1:0]             present_ff, present_in;
   logic [NUM_RUNS-1:0]             finished_ff, finished_in;
   logic [CNT_BITS-1:0]             addr_ff, addr_in;
   logic                            pend_ff, pend_in;
   logic [RUN_IDX_BITS-1:0]         pend_idx_ff, pend_idx_in;
   logic                            found_ff, found_in;
   logic [KEY_BITS-1:0]             best_key_ff, best_key_in;
   logic [kwm_pkg::VALUE_BITS-1:0]  best_value_ff, best_value_in;
   logic                            best_tomb_ff, best_tomb_in;
   logic [NUM_RUNS-1:0]             best_mask_ff, best_mask_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   kwm_pkg::rsp_payload_type        rsp_data_ff, rsp_data_in;

   logic [CNT_BITS-1:0]             run_count;
   logic [CMP_BITS-1:0]             active_wide;
   logic [NUM_RUNS-1:0]             active_mask;
   logic                            req_accept;
   logic                            run_in_range;
   logic [RUN_IDX_BITS-1:0]         run_sel;
   logic                            head_write;
   logic                            heads_ready;
   logic                            issue;
   logic [HEAD_BITS-1:0]            rd_data;
   logic [KEY_BITS-1:0]             rd_key;
   logic [kwm_pkg::VALUE_BITS-1:0]  rd_value;
   logic                            rd_tomb;
   logic                            pend_hit;
   logic [NUM_RUNS-1:0]             pend_bit;
   logic                            load_out;
   logic [NUM_RUNS-1:0]             present_left;
   logic                            emit;
   logic                            merge_done;

   // Active run count, saturated to the number of runs built.
   assign active_wide = CMP_BITS'(active_ff);
   assign run_count   = (active_wide > CMP_BITS'(NUM_RUNS)) ?
                        CNT_BITS'(NUM_RUNS) : CNT_BITS'(active_ff);

   always_comb begin
      for (int i = 0; i < NUM_RUNS; i++) begin
         active_mask[i] = CNT_BITS'(i) < run_count;
      end
   end

   assign req_if.ready = (state_ff == S_IDLE);
   assign req_accept   = req_if.valid && req_if.ready;
   assign run_in_range = CMP_BITS'(req_if.data.run_index) < CMP_BITS'(run_count);
   assign run_sel      = RUN_IDX_BITS'(req_if.data.run_index);
   assign head_write   = req_accept && run_in_range && !req_if.data.run_end &&
                         !present_ff[run_sel] && !finished_ff[run_sel];

   assign heads_ready  = ((present_ff | finished_ff) & active_mask) == active_mask;
   assign issue        = addr_ff < run_count;

   kwm_ram #(
      .WIDTH (HEAD_BITS),
      .DEPTH (NUM_RUNS)
   ) u_heads (
      .clock   (clock),
      .wr_en   (head_write),
      .wr_addr (run_sel),
      .wr_data ({KEY_BITS'(req_if.data.entry_key), req_if.data.entry_value,
                 req_if.data.entry_tombstone}),
      .rd_addr (addr_ff[RUN_IDX_BITS-1:0]),
      .rd_data (rd_data)
   );

   assign rd_key   = rd_data[HEAD_BITS-1 -: KEY_BITS];
   assign rd_value = rd_data[kwm_pkg::VALUE_BITS:1];
   assign rd_tomb  = rd_data[0];
   assign pend_hit = pend_ff && present_ff[pend_idx_ff];

   always_comb begin
      pend_bit              = '0;
      pend_bit[pend_idx_ff] = 1'b1;
   end

   assign load_out     = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_if.ready);
   assign present_left = present_ff & ~best_mask_ff;
   assign emit         = found_ff && !(drop_ff && best_tomb_ff);
   assign merge_done   = ((finished_ff & active_mask) == active_mask) &&
                         ((present_left & active_mask) == '0);

   always_comb begin
      state_in      = state_ff;
      present_in    = present_ff;
      finished_in   = finished_ff;
      addr_in       = addr_ff;
      pend_in       = pend_ff;
      pend_idx_in   = pend_idx_ff;
      found_in      = found_ff;
      best_key_in   = best_key_ff;
      best_value_in = best_value_ff;
      best_tomb_in  = best_tomb_ff;
      best_mask_in  = best_mask_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;

      if (rsp_valid_ff && rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               if (run_in_range && req_if.data.run_end) begin
                  finished_in[run_sel] = 1'b1;
               end
               if (head_write) begin
                  present_in[run_sel] = 1'b1;
               end
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            addr_in      = '0;
            pend_in      = 1'b0;
            found_in     = 1'b0;
            best_mask_in = '0;
            if (heads_ready && ((present_ff & active_mask) != '0)) begin
               state_in = S_SCAN;
            end else begin
               state_in = S_DONE;
            end
         end
         S_SCAN: begin
            // one head read per cycle; its data comes from the registered RAM read and is compared under pend_ff
            pend_in     = issue;
            pend_idx_in = addr_ff[RUN_IDX_BITS-1:0];
            if (issue) begin
               addr_in = addr_ff + 1'b1;
            end
            if (pend_hit && (!found_ff || rd_key <= best_key_ff)) begin
               found_in      = 1'b1;
               best_key_in   = rd_key;
               best_value_in = rd_value;
               best_tomb_in  = rd_tomb;
               // equal key from a younger run: older copies stay in the mask
               if (found_ff && rd_key == best_key_ff) begin
                  best_mask_in = best_mask_ff | pend_bit;
               end else begin
                  best_mask_in = pend_bit;
               end
            end
            if (!issue && !pend_ff) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (load_out) begin
               present_in                = present_left;
               rsp_valid_in              = 1'b1;
               rsp_data_in.out_valid     = emit;
               rsp_data_in.out_key       = emit ?
                                           kwm_pkg::KEY_FIELD_BITS'(best_key_ff) : '0;
               rsp_data_in.out_value     = emit ? best_value_ff : '0;
               rsp_data_in.out_tombstone = emit && best_tomb_ff;
               rsp_data_in.refill_mask   = kwm_pkg::REFILL_BITS'(best_mask_ff);
               rsp_data_in.merge_done    = merge_done;
               state_in                  = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         drop_ff      <= 1'b0;
         active_ff    <= kwm_pkg::ACTIVE_RESET;
         present_ff   <= '0;
         finished_ff  <= '0;
         pend_ff      <= 1'b0;
         found_ff     <= 1'b0;
         best_mask_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         present_ff   <= present_in;
         finished_ff  <= finished_in;
         pend_ff      <= pend_in;
         found_ff     <= found_in;
         best_mask_ff <= best_mask_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            case (kwm_pkg::csr_reg_type'(csr_addr))
               kwm_pkg::REG_DROP_TOMBSTONES: drop_ff   <= csr_wdata[0];
               kwm_pkg::REG_ACTIVE_RUNS:     active_ff <= csr_wdata;
               default: begin
               end
            endcase
         end
      end
      addr_ff       <= addr_in;
      pend_idx_ff   <= pend_idx_in;
      best_key_ff   <= best_key_in;
      best_value_ff <= best_value_in;
      best_tomb_ff  <= best_tomb_in;
      rsp_data_ff   <= rsp_data_in;
   end

   assign rsp_if.valid = rsp_valid_ff;
   assign rsp_if.data  = rsp_data_ff;

   // consumed heads must have been present
   `KWM_ASSERT(a_refill_subset, clock, reset, load_out |-> ((best_mask_ff & ~present_ff) == '0))
   // an emitted entry always consumes at least its own head
   `KWM_ASSERT(a_emit_has_refill, clock, reset, (load_out && emit) |-> (best_mask_ff != '0))
   // output register is never overwritten while a result waits
   `KWM_ASSERT_MSG(a_no_overwrite, clock, reset, load_out |-> (!rsp_valid_ff || rsp_if.ready), "kwm result overwritten")
   // a winner exists exactly when its refill mask is not empty
   `KWM_ASSERT(a_found_mask, clock, reset, load_out |-> (found_ff == (best_mask_ff != '0)))

endmodule

// ===== tb/sv/tb_kway_merge_newest_wins.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// K-way merge, newest wins: self-checking testbench
// Feeds run entries and end marks under several run counts and tombstone
// settings, predicts each merged transaction in a local model of the head
// store, and compares every field of the result stream against it.
// ----------------------------------------------------------------------------
module tb_kway_merge_newest_wins;
   import kwm_pkg::*;

   localparam int NUM_RUNS    = NUM_RUNS_DEFAULT;
   localparam int MAX_IDLE    = 18;
   localparam int LONG_HOLD   = 400;
   localparam int HOLD_AFTER  = 300;
   localparam int QUIET_LIMIT = 2000;
   localparam int SETTLE      = 4;
   localparam int TAIL_CYCLES = 40;
   localparam int PHASE_ITEMS = 125;
   localparam int MAX_REPORTS = 10;

   typedef struct packed {
      logic [NUM_RUNS-1:0][KEY_FIELD_BITS-1:0] head_key;
      logic [NUM_RUNS-1:0][VALUE_BITS-1:0]     head_value;
      logic [NUM_RUNS-1:0]                     head_tomb;
      logic [NUM_RUNS-1:0]                     head_present;
      logic [NUM_RUNS-1:0]                     run_finished;
      logic                                    drop_tombstones;
      logic [ACTIVE_BITS-1:0]                  active_runs;
   } merge_state_type;

   logic                     clock;
   logic                     reset;
   logic                     csr_we;
   logic [CSR_ADDR_BITS-1:0] csr_addr;
   logic [CSR_DATA_BITS-1:0] csr_wdata;

   kwm_stream_if #(.payload_type(req_payload_type)) req_chan ();
   kwm_stream_if #(.payload_type(rsp_payload_type)) rsp_chan ();

   kway_merge_newest_wins u_top (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .req_if    (req_chan),
      .rsp_if    (rsp_chan)
   );

   req_payload_type pending_entries [$];
   rsp_payload_type merged_due [$];
   merge_state_type merge_model;   // tracks accepted transactions
   merge_state_type plan_state;    // tracks the stimulus as it is queued
   logic            plan_done;
   logic [KEY_FIELD_BITS-1:0] run_cursor [NUM_RUNS];
   int              phase_runs [12] = '{1, 8, 0, 15, 3, 5, 2, 9, 7, 4, 8, 6};

   bit idle_on;
   bit req_busy;
   bit req_taken;
   bit rsp_taken;
   int req_gap;
   int rsp_wait;
   int rsp_count;
   int error_count;

   function automatic merge_state_type fresh_merge_state();
      merge_state_type st;
      st = '0;
      st.active_runs = ACTIVE_RESET;
      return st;
   endfunction

   // runs taking part; counts above NUM_RUNS saturate
   function automatic logic [NUM_RUNS-1:0] run_mask(input merge_state_type st);
      logic [NUM_RUNS-1:0] m;
      m = '0;
      for (int i = 0; i < NUM_RUNS; i++) m[i] = (i < st.active_runs);
      return m;
   endfunction

   function automatic rsp_payload_type advance_merge(inout merge_state_type st,
                                                     input req_payload_type item);
      rsp_payload_type     res;
      logic [NUM_RUNS-1:0] amask;
      logic [NUM_RUNS-1:0] live;
      logic [NUM_RUNS-1:0] refill;
      logic [KEY_FIELD_BITS-1:0] k;
      int                  win;
      res    = '0;
      refill = '0;
      win    = -1;
      amask  = run_mask(st);
      if (amask[item.run_index]) begin
         if (item.run_end) begin
            st.run_finished[item.run_index] = 1'b1;
         end else if (!st.head_present[item.run_index] &&
                      !st.run_finished[item.run_index]) begin
            st.head_key[item.run_index]     = item.entry_key;
            st.head_value[item.run_index]   = item.entry_value;
            st.head_tomb[item.run_index]    = item.entry_tombstone;
            st.head_present[item.run_index] = 1'b1;
         end
      end
      // some active run still waits for its head or end mark
      if (((st.head_present | st.run_finished) & amask) != amask) return res;
      live = st.head_present & amask;
      for (int i = 0; i < NUM_RUNS; i++)
         if (live[i] && (win < 0 || st.head_key[i] <= st.head_key[win])) win = i;
      if (win >= 0) begin
         k = st.head_key[win];
         for (int i = 0; i < NUM_RUNS; i++)
            if (live[i] && st.head_key[i] == k) refill[i] = 1'b1;
         st.head_present = st.head_present & ~refill;
         if (!(st.drop_tombstones && st.head_tomb[win])) begin
            res.out_valid     = 1'b1;
            res.out_key       = k;
            res.out_value     = st.head_value[win];
            res.out_tombstone = st.head_tomb[win];
         end
      end
      res.refill_mask = refill;
      res.merge_done  = ((st.run_finished & amask) == amask) &&
                        ((st.head_present & amask) == '0);
      return res;
   endfunction

   function automatic int idle_draw();
      return idle_on ? int'($urandom_range(MAX_IDLE, 0)) : 0;
   endfunction

   task automatic queue_item(input int run, input logic ended,
                             input logic [KEY_FIELD_BITS-1:0] key,
                             input logic [VALUE_BITS-1:0] value, input logic tomb);
      req_payload_type item;
      rsp_payload_type outcome;
      item.run_index       = run[RUN_INDEX_BITS-1:0];
      item.run_end         = ended;
      item.entry_key       = key;
      item.entry_value     = value;
      item.entry_tombstone = tomb;
      outcome   = advance_merge(plan_state, item);
      plan_done = outcome.merge_done;
      pending_entries.push_back(item);
   endtask

   // mostly refills of runs that lack a head, keys non-decreasing per run; the rest
   // is noise: foreign runs, runs already holding a head, stray end marks
   task automatic queue_traffic(input bit with_ends);
      logic [NUM_RUNS-1:0] needy;
      int                  r;
      needy = run_mask(plan_state) & ~plan_state.head_present & ~plan_state.run_finished;
      if (needy != '0 && $urandom_range(99, 0) < 85) begin
         do r = $urandom_range(NUM_RUNS-1, 0); while (!needy[r]);
         if (with_ends && $urandom_range(99, 0) < 12) begin
            queue_item(r, 1'b1, {$urandom, $urandom}, {$urandom, $urandom}, 1'b0);
         end else begin
            run_cursor[r] = run_cursor[r] + $urandom_range(3, 0);
            queue_item(r, 1'b0, run_cursor[r], {$urandom, $urandom},
                       $urandom_range(3, 0) == 0);
         end
      end else begin
         r = $urandom_range(NUM_RUNS-1, 0);
         queue_item(r, with_ends && $urandom_range(1, 0), {$urandom, $urandom},
                    {$urandom, $urandom}, $urandom_range(1, 0));
      end
   endtask

   // keys of all runs cluster around one base so equal keys are common
   task automatic new_key_epoch();
      logic [KEY_FIELD_BITS-1:0] base;
      base = {$urandom, $urandom};
      for (int i = 0; i < NUM_RUNS; i++) run_cursor[i] = base + $urandom_range(3, 0);
   endtask

   task automatic wait_drained();
      while (pending_entries.size() != 0 || req_busy || merged_due.size() != 0)
         @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   task automatic program_merge(input logic drop, input logic [ACTIVE_BITS-1:0] runs);
      wait_drained();
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= REG_DROP_TOMBSTONES;
      csr_wdata <= {{(CSR_DATA_BITS-1){1'b0}}, drop};
      @(negedge clock);
      csr_addr  <= REG_ACTIVE_RUNS;
      csr_wdata <= runs;
      @(negedge clock);
      csr_we <= 1'b0;
      merge_model.drop_tombstones = drop;
      merge_model.active_runs     = runs;
      plan_state.drop_tombstones  = drop;
      plan_state.active_runs      = runs;
   endtask

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // request driver
   always @(negedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
         req_busy = 1'b0;
         req_gap  = 0;
      end else begin
         if (req_busy && req_taken) begin
            req_busy = 1'b0;
            req_gap  = idle_draw();
         end
         if (!req_busy) begin
            if (req_gap > 0) begin
               req_gap--;
            end else if (pending_entries.size() != 0) begin
               req_chan.data <= pending_entries.pop_front();
               req_busy = 1'b1;
            end
         end
         req_chan.valid <= req_busy;
      end
   end

   // result ready, with one long hold-off to back the block up
   always @(negedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         rsp_wait = 0;
      end else begin
         if (rsp_taken) rsp_wait = (rsp_count == HOLD_AFTER) ? LONG_HOLD : idle_draw();
         if (rsp_wait > 0) begin
            rsp_wait--;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   // monitor: check results first, then predict the accepted request
   always @(posedge clock) begin : monitor
      rsp_payload_type got;
      rsp_payload_type want;
      req_taken = 1'b0;
      rsp_taken = 1'b0;
      if (!reset) begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            rsp_taken = 1'b1;
            rsp_count++;
            got = rsp_chan.data;
            if (merged_due.size() == 0) begin
               error_count++;
               if (error_count <= MAX_REPORTS)
                  $display("%0t: result transaction with nothing outstanding, key %h",
                           $time, got.out_key);
            end else begin
               want = merged_due.pop_front();
               if (got.out_valid !== want.out_valid || got.out_key !== want.out_key ||
                   got.out_value !== want.out_value ||
                   got.out_tombstone !== want.out_tombstone ||
                   got.refill_mask !== want.refill_mask ||
                   got.merge_done !== want.merge_done) begin
                  error_count++;
                  if (error_count <= MAX_REPORTS)
                     $display({"%0t: mismatch (expected/actual) valid %0b/%0b key %h/%h",
                               " value %h/%h tomb %0b/%0b refill %h/%h done %0b/%0b"},
                              $time, want.out_valid, got.out_valid, want.out_key,
                              got.out_key, want.out_value, got.out_value,
                              want.out_tombstone, got.out_tombstone, want.refill_mask,
                              got.refill_mask, want.merge_done, got.merge_done);
               end
            end
         end
         if (req_chan.valid && req_chan.ready) begin
            req_taken = 1'b1;
            merged_due.push_back(advance_merge(merge_model, req_chan.data));
         end
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if (reset || csr_we || (req_chan.valid && req_chan.ready) ||
             (rsp_chan.valid && rsp_chan.ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("kway_merge_newest_wins regression: fail");
      $finish;
   end

   initial begin : stimulus
      int guard;
      reset          = 1'b1;
      csr_we         = 1'b0;
      csr_addr       = REG_DROP_TOMBSTONES;
      csr_wdata      = '0;
      req_chan.valid = 1'b0;
      req_chan.data  = '0;
      rsp_chan.ready = 1'b0;
      idle_on        = 1'b1;
      rsp_count      = 0;
      error_count    = 0;
      plan_done      = 1'b0;
      merge_model    = fresh_merge_state();
      plan_state     = fresh_merge_state();
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset config: all eight runs, tombstones kept
      queue_item(0, 1'b0, '0, '1, 1'b0);
      queue_item(0, 1'b0, 64'h5, '0, 1'b1);                  // run already holds a head
      queue_item(1, 1'b0, '1, '0, 1'b0);
      queue_item(2, 1'b0, '0, 64'h2222, 1'b0);
      queue_item(3, 1'b0, 64'h8000_0000_0000_0000, 64'h3333, 1'b0);
      queue_item(4, 1'b0, 64'h100, 64'h4444, 1'b1);
      queue_item(5, 1'b0, 64'h100, 64'h5555, 1'b0);
      queue_item(6, 1'b0, 64'h7fff_ffff_ffff_ffff, 64'h6666, 1'b0);
      queue_item(7, 1'b0, '0, 64'h7777, 1'b1);               // youngest zero key wins
      // tombstone winner is consumed silently
      program_merge(1'b1, 4'd8);
      queue_item(7, 1'b0, 64'h100, 64'h7070, 1'b1);
      queue_item(0, 1'b0, 64'h100, 64'h0101, 1'b0);
      queue_item(2, 1'b0, 64'h100, 64'h0202, 1'b0);
      queue_item(0, 1'b0, '1, '1, 1'b1);
      queue_item(4, 1'b0, '0, '1, 1'b0);

      for (int p = 0; p < 12; p++) begin
         program_merge(p % 2, phase_runs[p]);
         idle_on = (p % 4 != 3);
         new_key_epoch();
         for (int i = 0; i < ((phase_runs[p] == 0) ? 12 : PHASE_ITEMS); i++)
            queue_traffic(1'b0);
      end

      // closing merge: runs end one by one until the merge finishes
      program_merge($urandom_range(1, 0), 4'd8);
      idle_on = 1'b1;
      new_key_epoch();
      guard = 0;
      while (!plan_done && guard < 2000) begin
         queue_traffic(1'b1);
         guard++;
      end
      for (int i = 0; i < 4; i++) queue_traffic(1'b0);

      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      error_count += merged_due.size();
      if (error_count == 0)
         $display("kway_merge_newest_wins regression: pass");
      else
         $display("kway_merge_newest_wins regression: fail");
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+design
design/kwm_pkg.sv
design/kwm_stream_if.sv
design/kwm_ram.sv
design/kway_merge_newest_wins.sv
tb/sv/tb_kway_merge_newest_wins.sv
